// ===== rtl/core/szaf_pkg.sv =====
package szaf_pkg;

    localparam int DEF_MAX_ENTRIES      = 256;
    localparam int DEF_NAME_STORE_BYTES = 16384;
    localparam int DEF_MAX_NAME_LEN     = 1024;

    localparam logic [2:0] OP_START = 3'd0;
    localparam logic [2:0] OP_NAME  = 3'd1;
    localparam logic [2:0] OP_DATA  = 3'd2;
    localparam logic [2:0] OP_END   = 3'd3;
    localparam logic [2:0] OP_PULL  = 3'd4;

    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_NAME_LONG = 3'd1;
    localparam logic [2:0] ERR_TBL_FULL  = 3'd2;
    localparam logic [2:0] ERR_SIZE_OVF  = 3'd3;
    localparam logic [2:0] ERR_NAME_FULL = 3'd4;

    localparam logic CFG_DOS_TIME = 1'b0;
    localparam logic CFG_DOS_DATE = 1'b1;

    localparam logic [1:0] CMD_BYTE = 2'd0;
    localparam logic [1:0] CMD_HDR  = 2'd1;
    localparam logic [1:0] CMD_DESC = 2'd2;

    localparam logic [31:0] SIG_LOCAL = 32'h04034b50;
    localparam logic [31:0] SIG_DESC  = 32'h08074b50;
    localparam logic [31:0] SIG_CDIR  = 32'h02014b50;
    localparam logic [31:0] SIG_EOCD  = 32'h06054b50;
    localparam logic [15:0] GP_FLAGS  = 16'h0808;
    localparam logic [15:0] VER_MADE  = 16'h0314;
    localparam logic [15:0] VER_NEED  = 16'd20;
    localparam logic [3:0]  MODE_REG  = 4'h8;
    localparam logic [31:0] CRC_POLY  = 32'hEDB88320;
    localparam logic [31:0] CRC_INIT  = 32'hFFFFFFFF;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  data;
        logic        valid;
        logic        done;
        logic [2:0]  err;
        logic [31:0] crc;
        logic [31:0] size;
        logic [10:0] nlen;
        logic [15:0] dtime;
        logic [15:0] ddate;
    } t_cmd;

    function automatic logic [7:0] le_byte(input logic [31:0] v, input logic [1:0] i);
        return v[8*i +: 8];
    endfunction

    function automatic logic [31:0] crc_step(input logic [31:0] c, input logic [7:0] b);
        logic [31:0] x;
        x = c ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            x = x[0] ? (CRC_POLY ^ (x >> 1)) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ===== rtl/core/stored_zip_archive_framer.sv =====
// Stored ZIP framer: one input transfer is taken per cycle while the command queue has room;
// a local header expands to 30 output transfers, a data descriptor to 16, every other item to
// one, so output pacing is set by the byte expander at one transfer per cycle while m_axis_tready
// holds. Data bytes run a CRC-32 step. Central-directory bytes come one per pull from the entry
// table and name store, whose registered reads track the trailer cursor. Errors are sticky.
module stored_zip_archive_framer #(
    parameter int MAX_ENTRIES      = szaf_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_STORE_BYTES = szaf_pkg::DEF_NAME_STORE_BYTES,
    parameter int MAX_NAME_LEN     = szaf_pkg::DEF_MAX_NAME_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // byte_value[7:0], name_length[18:8], perm_mode[30:19]
    input  logic [2:0]  s_axis_tuser,   // operation
    input  logic        i_cfg_we,
    input  logic        i_cfg_addr,
    input  logic [15:0] i_cfg_wdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // byte_out[7:0], archive_done[8], error_code[11:9]
    output logic        m_axis_tuser,   // byte_valid
    output logic        m_axis_tlast    // last_of_run
);
    import szaf_pkg::*;

    t_cmd w_fcmd, w_qcmd;
    logic w_push, w_full, w_pop, w_qvalid;

    szaf_front #(
        .MAX_ENTRIES      (MAX_ENTRIES),
        .NAME_STORE_BYTES (NAME_STORE_BYTES),
        .MAX_NAME_LEN     (MAX_NAME_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_op        (s_axis_tuser),
        .i_byte      (s_axis_tdata[7:0]),
        .i_nlen      (s_axis_tdata[18:8]),
        .i_mode      (s_axis_tdata[30:19]),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_full    (w_full),
        .o_push      (w_push),
        .o_cmd       (w_fcmd)
    );

    szaf_queue #(.DEPTH(2)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_fcmd),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_qvalid),
        .o_cmd   (w_qcmd)
    );

    szaf_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qvalid),
        .i_cmd     (w_qcmd),
        .o_pop     (w_pop),
        .o_tvalid  (m_axis_tvalid),
        .i_tready  (m_axis_tready),
        .o_tdata   (m_axis_tdata),
        .o_tuser   (m_axis_tuser),
        .o_tlast   (m_axis_tlast)
    );
endmodule

// ===== rtl/core/szaf_queue.sv =====
module szaf_queue #(
    parameter int DEPTH = 2
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  szaf_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output szaf_pkg::t_cmd  o_cmd
);
    import szaf_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wp, r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(DEPTH-1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(DEPTH-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (PW+1)'(i_push) - (PW+1)'(i_pop);
        end
    end
endmodule

// ===== rtl/core/szaf_front.sv =====
module szaf_front #(
    parameter int MAX_ENTRIES      = szaf_pkg::DEF_MAX_ENTRIES,
    parameter int NAME_STORE_BYTES = szaf_pkg::DEF_NAME_STORE_BYTES,
    parameter int MAX_NAME_LEN     = szaf_pkg::DEF_MAX_NAME_LEN
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [2:0]      i_op,
    input  logic [7:0]      i_byte,
    input  logic [10:0]     i_nlen,
    input  logic [11:0]     i_mode,
    input  logic            i_cfg_we,
    input  logic            i_cfg_addr,
    input  logic [15:0]     i_cfg_wdata,
    input  logic            i_q_full,
    output logic            o_push,
    output szaf_pkg::t_cmd  o_cmd
);
    import szaf_pkg::*;

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_NAME    = 3'd1;
    localparam logic [2:0] PH_DATA    = 3'd2;
    localparam logic [2:0] PH_TRAILER = 3'd3;
    localparam logic [2:0] PH_DONE    = 3'd4;

    localparam int EW  = $clog2(MAX_ENTRIES + 1);
    localparam int TW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int NFW = $clog2(NAME_STORE_BYTES + 1);
    localparam int NAW = $clog2(NAME_STORE_BYTES);
    localparam int CW  = $clog2(46 + MAX_NAME_LEN + 1);
    localparam int SW  = ((NFW > CW) ? NFW : CW) + 1;

    typedef struct packed {
        logic [31:0]    crc;
        logic [31:0]    size;
        logic [31:0]    offset;
        logic [NFW-1:0] nstart;
        logic [10:0]    nlen;
        logic [11:0]    mode;
    } t_row;

    t_row           r_tbl [MAX_ENTRIES];
    logic [7:0]     r_names [NAME_STORE_BYTES];
    t_row           r_row;
    logic [7:0]     r_name;

    logic [15:0]    r_time, r_date;
    logic [31:0]    r_offset, n_offset;
    logic [31:0]    r_crc, n_crc;
    logic [31:0]    r_size, n_size;
    logic [EW-1:0]  r_count, n_count;
    logic [NFW-1:0] r_fill, n_fill;
    logic [2:0]     r_phase, n_phase;
    logic [CW-1:0]  r_cursor, n_cursor;
    logic [31:0]    r_dirstart, n_dirstart;
    logic [2:0]     r_fail, n_fail;
    logic [10:0]    r_left, n_left;
    logic [EW-1:0]  r_tentry, n_tentry;
    t_row           r_pend, n_pend;

    logic           w_acc;
    logic           w_tbl_we, w_name_we;
    logic [SW-1:0]  w_nsum;
    logic [CW-1:0]  w_pos;
    logic [31:0]    w_cd;
    logic [31:0]    w_attr;
    logic [7:0]     w_cdb;
    logic [7:0]     w_eob;

    assign w_acc   = i_valid && !i_q_full;
    assign o_ready = !i_q_full;
    assign o_push  = w_acc;
    assign w_nsum  = SW'(r_row.nstart) + SW'(n_cursor) - SW'(46);
    assign w_pos   = (r_cursor < CW'(22)) ? r_cursor : CW'(21);
    assign w_cd    = r_offset - 32'(w_pos) - r_dirstart;
    assign w_attr  = {MODE_REG, r_row.mode, 16'd0};

    always_comb begin
        case (r_cursor[5:0])
            6'd0, 6'd1, 6'd2, 6'd3:     w_cdb = le_byte(SIG_CDIR, r_cursor[1:0]);
            6'd4:                       w_cdb = VER_MADE[7:0];
            6'd5:                       w_cdb = VER_MADE[15:8];
            6'd6:                       w_cdb = VER_NEED[7:0];
            6'd8:                       w_cdb = GP_FLAGS[7:0];
            6'd9:                       w_cdb = GP_FLAGS[15:8];
            6'd12:                      w_cdb = r_time[7:0];
            6'd13:                      w_cdb = r_time[15:8];
            6'd14:                      w_cdb = r_date[7:0];
            6'd15:                      w_cdb = r_date[15:8];
            6'd16, 6'd17, 6'd18, 6'd19: w_cdb = le_byte(r_row.crc, r_cursor[1:0]);
            6'd20, 6'd21, 6'd22, 6'd23: w_cdb = le_byte(r_row.size, r_cursor[1:0]);
            6'd24, 6'd25, 6'd26, 6'd27: w_cdb = le_byte(r_row.size, r_cursor[1:0]);
            6'd28:                      w_cdb = r_row.nlen[7:0];
            6'd29:                      w_cdb = {5'd0, r_row.nlen[10:8]};
            6'd38, 6'd39, 6'd40, 6'd41: w_cdb = le_byte(w_attr, 2'(r_cursor[5:0] - 6'd38));
            6'd42, 6'd43, 6'd44, 6'd45: w_cdb = le_byte(r_row.offset, 2'(r_cursor[5:0] - 6'd42));
            default:                    w_cdb = 8'd0;
        endcase
    end

    always_comb begin
        case (w_pos[4:0])
            5'd0, 5'd1, 5'd2, 5'd3:     w_eob = le_byte(SIG_EOCD, w_pos[1:0]);
            5'd8, 5'd10:                w_eob = le_byte(32'(r_count), 2'd0);
            5'd9, 5'd11:                w_eob = le_byte(32'(r_count), 2'd1);
            5'd12, 5'd13, 5'd14, 5'd15: w_eob = le_byte(w_cd, w_pos[1:0]);
            5'd16, 5'd17, 5'd18, 5'd19: w_eob = le_byte(r_dirstart, w_pos[1:0]);
            default:                    w_eob = 8'd0;
        endcase
    end

    always_comb begin
        n_offset   = r_offset;
        n_crc      = r_crc;
        n_size     = r_size;
        n_count    = r_count;
        n_fill     = r_fill;
        n_phase    = r_phase;
        n_cursor   = r_cursor;
        n_dirstart = r_dirstart;
        n_fail     = r_fail;
        n_left     = r_left;
        n_tentry   = r_tentry;
        n_pend     = r_pend;
        w_tbl_we   = 1'b0;
        w_name_we  = 1'b0;
        o_cmd       = '0;
        o_cmd.kind  = CMD_BYTE;
        o_cmd.dtime = r_time;
        o_cmd.ddate = r_date;
        o_cmd.nlen  = i_nlen;
        if (w_acc && r_fail == ERR_OK) begin
            if (i_op == OP_START && r_phase == PH_IDLE) begin
                if (32'(i_nlen) > 32'(MAX_NAME_LEN)) begin
                    n_fail = ERR_NAME_LONG;
                end else if (32'(r_count) >= 32'(MAX_ENTRIES)) begin
                    n_fail = ERR_TBL_FULL;
                end else if (32'(r_fill) + 32'(i_nlen) > 32'(NAME_STORE_BYTES)) begin
                    n_fail = ERR_NAME_FULL;
                end else begin
                    o_cmd.kind    = CMD_HDR;
                    o_cmd.valid   = 1'b1;
                    n_pend.offset = r_offset;
                    n_pend.nstart = r_fill;
                    n_pend.nlen   = i_nlen;
                    n_offset      = r_offset + 32'd30;
                    n_crc         = CRC_INIT;
                    n_size        = '0;
                    n_left        = i_nlen;
                    n_phase       = (i_nlen != '0) ? PH_NAME : PH_DATA;
                end
            end else if (i_op == OP_NAME && r_phase == PH_NAME) begin
                w_name_we   = 1'b1;
                n_fill      = r_fill + 1'b1;
                o_cmd.data  = i_byte;
                o_cmd.valid = 1'b1;
                n_offset    = r_offset + 32'd1;
                n_left      = r_left - 1'b1;
                if (r_left == 11'd1) begin
                    n_phase = PH_DATA;
                end
            end else if (i_op == OP_DATA && r_phase == PH_DATA) begin
                if (r_size == '1) begin
                    n_fail = ERR_SIZE_OVF;
                end else begin
                    n_crc       = crc_step(r_crc, i_byte);
                    n_size      = r_size + 32'd1;
                    o_cmd.data  = i_byte;
                    o_cmd.valid = 1'b1;
                    n_offset    = r_offset + 32'd1;
                end
            end else if (i_op == OP_END && r_phase == PH_DATA) begin
                o_cmd.kind  = CMD_DESC;
                o_cmd.valid = 1'b1;
                o_cmd.crc   = ~r_crc;
                o_cmd.size  = r_size;
                n_offset    = r_offset + 32'd16;
                n_pend.crc  = ~r_crc;
                n_pend.size = r_size;
                n_pend.mode = i_mode;
                w_tbl_we    = (32'(r_count) < 32'(MAX_ENTRIES));
                n_count     = r_count + 1'b1;
                n_crc       = CRC_INIT;
                n_size      = '0;
                n_phase     = PH_IDLE;
            end else if (i_op == OP_PULL && r_phase == PH_IDLE) begin
                n_dirstart = r_offset;
                n_cursor   = '0;
                n_tentry   = '0;
                n_phase    = PH_TRAILER;
            end else if (i_op == OP_PULL && r_phase == PH_TRAILER) begin
                o_cmd.valid = 1'b1;
                n_offset    = r_offset + 32'd1;
                if (r_tentry < r_count) begin
                    o_cmd.data = (r_cursor < CW'(46)) ? w_cdb : r_name;
                    if ((CW+1)'(r_cursor) + 1'b1 >= (CW+1)'(46) + (CW+1)'(r_row.nlen)) begin
                        n_cursor = '0;
                        n_tentry = r_tentry + 1'b1;
                    end else begin
                        n_cursor = r_cursor + 1'b1;
                    end
                end else begin
                    o_cmd.data = w_eob;
                    n_cursor   = w_pos + 1'b1;
                    if (w_pos == CW'(21)) begin
                        o_cmd.done = 1'b1;
                        n_phase    = PH_DONE;
                    end
                end
            end
        end
        if (!o_cmd.valid) begin
            o_cmd.done = (n_phase == PH_DONE);
        end
        o_cmd.err = n_fail;
    end

    always_ff @(posedge i_clk) begin
        if (w_tbl_we) begin
            r_tbl[r_count[TW-1:0]] <= n_pend;
        end
        r_row <= r_tbl[n_tentry[TW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (w_name_we) begin
            r_names[r_fill[NAW-1:0]] <= i_byte;
        end
        r_name <= r_names[w_nsum[NAW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time     <= 16'd0;
            r_date     <= 16'd33;
            r_offset   <= '0;
            r_crc      <= CRC_INIT;
            r_size     <= '0;
            r_count    <= '0;
            r_fill     <= '0;
            r_phase    <= PH_IDLE;
            r_cursor   <= '0;
            r_dirstart <= '0;
            r_fail     <= ERR_OK;
            r_left     <= '0;
            r_tentry   <= '0;
            r_pend     <= '0;
        end else begin
            if (i_cfg_we && i_cfg_addr == CFG_DOS_TIME) begin
                r_time <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_addr == CFG_DOS_DATE) begin
                r_date <= i_cfg_wdata;
            end
            r_offset   <= n_offset;
            r_crc      <= n_crc;
            r_size     <= n_size;
            r_count    <= n_count;
            r_fill     <= n_fill;
            r_phase    <= n_phase;
            r_cursor   <= n_cursor;
            r_dirstart <= n_dirstart;
            r_fail     <= n_fail;
            r_left     <= n_left;
            r_tentry   <= n_tentry;
            r_pend     <= n_pend;
        end
    end
endmodule

// ===== rtl/core/szaf_back.sv =====
module szaf_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    input  szaf_pkg::t_cmd  i_cmd,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [15:0]     o_tdata,
    output logic            o_tuser,
    output logic            o_tlast
);
    import szaf_pkg::*;

    logic [4:0] r_idx;
    logic [4:0] w_last_idx;
    logic       w_adv, w_emit, w_end;
    logic [7:0] w_byte;
    logic       r_ovalid;
    logic [7:0] r_obyte;
    logic       r_ovld_flag, r_olast, r_odone;
    logic [2:0] r_oerr;

    assign w_adv  = !r_ovalid || i_tready;
    assign w_emit = w_adv && i_q_valid;
    assign w_end  = (r_idx == w_last_idx);
    assign o_pop  = w_emit && w_end;

    always_comb begin
        case (i_cmd.kind)
            CMD_HDR:  w_last_idx = 5'd29;
            CMD_DESC: w_last_idx = 5'd15;
            default:  w_last_idx = 5'd0;
        endcase
    end

    always_comb begin
        w_byte = i_cmd.data;
        if (i_cmd.kind == CMD_HDR) begin
            case (r_idx)
                5'd0, 5'd1, 5'd2, 5'd3: w_byte = le_byte(SIG_LOCAL, r_idx[1:0]);
                5'd4:                   w_byte = VER_NEED[7:0];
                5'd6:                   w_byte = GP_FLAGS[7:0];
                5'd7:                   w_byte = GP_FLAGS[15:8];
                5'd10:                  w_byte = i_cmd.dtime[7:0];
                5'd11:                  w_byte = i_cmd.dtime[15:8];
                5'd12:                  w_byte = i_cmd.ddate[7:0];
                5'd13:                  w_byte = i_cmd.ddate[15:8];
                5'd26:                  w_byte = i_cmd.nlen[7:0];
                5'd27:                  w_byte = {5'd0, i_cmd.nlen[10:8]};
                default:                w_byte = 8'd0;
            endcase
        end else if (i_cmd.kind == CMD_DESC) begin
            case (r_idx[3:2])
                2'd0:    w_byte = le_byte(SIG_DESC, r_idx[1:0]);
                2'd1:    w_byte = le_byte(i_cmd.crc, r_idx[1:0]);
                default: w_byte = le_byte(i_cmd.size, r_idx[1:0]);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_obyte     <= w_byte;
            r_ovld_flag <= i_cmd.valid;
            r_olast     <= w_end;
            r_odone     <= i_cmd.done;
            r_oerr      <= i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (w_adv) begin
                r_ovalid <= i_q_valid;
            end
            if (w_emit) begin
                r_idx <= w_end ? 5'd0 : r_idx + 1'b1;
            end
        end
    end

    assign o_tvalid = r_ovalid;
    assign o_tdata  = {4'd0, r_oerr, r_odone, r_obyte};
    assign o_tuser  = r_ovld_flag;
    assign o_tlast  = r_olast;
endmodule
